// ===== sv/qif_neuron_update_defines.svh =====
// Assertion macros shared by the neuron update block.
`ifndef QIF_NEURON_UPDATE_DEFINES_SVH
`define QIF_NEURON_UPDATE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define QIF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qif assertion failed");
`define QIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qif assertion failed");
`else
`define QIF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define QIF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== sv/qif_pkg.sv =====
// Shared types and constants of the neuron update block.
package qif_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 32;
   localparam int unsigned COUP_NUM_W  = 47;
   localparam int unsigned DEG_W       = 16;
   localparam int unsigned SPK_NUM_W   = 37;
   localparam int unsigned SPK_DEN_W   = 31;
   localparam logic [20:0] REFR_MAX    = 21'd2000000;

   typedef enum logic [2:0] {
      CSR_THRESHOLD     = 3'd0,
      CSR_COUPLING_GAIN = 3'd1,
      CSR_STEP_SIZE     = 3'd2,
      CSR_TICKS_PER_SEC = 3'd3,
      CSR_STIM_LEVEL    = 3'd4,
      CSR_STIM_START    = 3'd5,
      CSR_STIM_END      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [30:0]        threshold;
      logic [30:0]        coupling_gain;
      logic [31:0]        step_size;
      logic [19:0]        ticks_per_second;
      logic signed [31:0] stimulus_level;
      logic signed [31:0] stimulus_start;
      logic signed [31:0] stimulus_end;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] now_tick;
      logic signed [31:0] potential;
      logic signed [31:0] drive;
      logic signed [31:0] last_spike_tick;
      logic [20:0]        refractory_ticks;
      logic               live;
      logic               stim_on;
      logic               coupled;
   } item_type;

   typedef struct packed {
      item_type                item;
      logic [COUP_NUM_W-1:0]   coup_num;
      logic [DEG_W-1:0]        degree;
   } entry_type;

endpackage

// ===== sv/qif_neuron_update.sv =====
// Top level of the quadratic integrate-and-fire neuron update block.
// Accepts one neuron item per clock while the queue is not full and returns one result
// item for each, in order. A result passes a 47-stage coupling divider, seven Euler
// stages, a 37-stage spike timing divider and three final stages.
// An item waits in the input queue only while the back end is stalled. Throughput is one
// item per cycle; a stalled result stalls the whole back end, and the input queue keeps
// accepting items until it fills.
module qif_neuron_update #(
   parameter int unsigned QUEUE_DEPTH = qif_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [31:0]                req_now_tick,
   input  logic signed [31:0]                req_potential,
   input  logic signed [31:0]                req_drive,
   input  logic [15:0]                       req_active_neighbours,
   input  logic [15:0]                       req_degree,
   input  logic signed [31:0]                req_last_spike_tick,
   input  logic [20:0]                       req_refractory_ticks,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [31:0]                rsp_new_potential,
   output logic                              rsp_spiked,
   output logic signed [31:0]                rsp_new_last_spike,
   output logic [20:0]                       rsp_new_refractory,
   output logic                              rsp_integrated,
   output logic                              rsp_counts_for_average,
   input  logic                              csr_write,
   input  logic [qif_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [qif_pkg::CSR_DATA_W-1:0]    csr_data
);
   import qif_pkg::*;

   cfg_type   cfg_ff;
   entry_type push_data, pop_data;
   logic      push, pop, full, empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold        <= 31'd6553600;
         cfg_ff.coupling_gain    <= 31'd983040000;
         cfg_ff.step_size        <= 32'd429497;
         cfg_ff.ticks_per_second <= 20'd10000;
         cfg_ff.stimulus_level   <= 32'sd196608;
         cfg_ff.stimulus_start   <= 32'sd0;
         cfg_ff.stimulus_end     <= 32'sd300000;
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD:     cfg_ff.threshold        <= csr_data[30:0];
            CSR_COUPLING_GAIN: cfg_ff.coupling_gain    <= csr_data[30:0];
            CSR_STEP_SIZE:     cfg_ff.step_size        <= csr_data;
            CSR_TICKS_PER_SEC: cfg_ff.ticks_per_second <= csr_data[19:0];
            CSR_STIM_LEVEL:    cfg_ff.stimulus_level   <= $signed(csr_data);
            CSR_STIM_START:    cfg_ff.stimulus_start   <= $signed(csr_data);
            CSR_STIM_END:      cfg_ff.stimulus_end     <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   assign req_ready = !full;

   qif_front u_front (
      .cfg(cfg_ff), .req_valid(req_valid),
      .req_now_tick(req_now_tick), .req_potential(req_potential), .req_drive(req_drive),
      .req_active_neighbours(req_active_neighbours), .req_degree(req_degree),
      .req_last_spike_tick(req_last_spike_tick), .req_refractory_ticks(req_refractory_ticks),
      .full(full), .push(push), .entry(push_data)
   );

   qif_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset), .push(push), .push_data(push_data),
      .pop(pop), .pop_data(pop_data), .full(full), .empty(empty)
   );

   qif_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .empty(empty), .pop_data(pop_data),
      .pop(pop), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_new_potential(rsp_new_potential), .rsp_spiked(rsp_spiked),
      .rsp_new_last_spike(rsp_new_last_spike), .rsp_new_refractory(rsp_new_refractory),
      .rsp_integrated(rsp_integrated), .rsp_counts_for_average(rsp_counts_for_average)
   );
endmodule

// ===== sv/qif_front.sv =====
// Front end: classifies each incoming item and forms the coupling numerator.
module qif_front (
   input  qif_pkg::cfg_type    cfg,
   input  logic                req_valid,
   input  logic signed [31:0]  req_now_tick,
   input  logic signed [31:0]  req_potential,
   input  logic signed [31:0]  req_drive,
   input  logic [15:0]         req_active_neighbours,
   input  logic [15:0]         req_degree,
   input  logic signed [31:0]  req_last_spike_tick,
   input  logic [20:0]         req_refractory_ticks,
   input  logic                full,
   output logic                push,
   output qif_pkg::entry_type  entry
);
   import qif_pkg::*;

   logic signed [33:0] since_spike;

   assign since_spike = {{2{req_now_tick[31]}}, req_now_tick}
                      - {{2{req_last_spike_tick[31]}}, req_last_spike_tick};
   assign push = req_valid && !full;

   always_comb begin
      entry.item.now_tick         = req_now_tick;
      entry.item.potential        = req_potential;
      entry.item.drive            = req_drive;
      entry.item.last_spike_tick  = req_last_spike_tick;
      entry.item.refractory_ticks = req_refractory_ticks;
      entry.item.live    = since_spike > $signed({13'b0, req_refractory_ticks});
      entry.item.stim_on = (req_now_tick >= cfg.stimulus_start)
                        && (req_now_tick <= cfg.stimulus_end);
      entry.item.coupled = req_degree != '0;
      entry.coup_num = COUP_NUM_W'(cfg.coupling_gain) * COUP_NUM_W'(req_active_neighbours);
      entry.degree   = req_degree;
   end
endmodule

// ===== sv/qif_queue.sv =====
// Short queue between the front end and the back end.
`include "qif_neuron_update_defines.svh"
module qif_queue #(
   parameter int unsigned DEPTH = qif_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  qif_pkg::entry_type push_data,
   input  logic               pop,
   output qif_pkg::entry_type pop_data,
   output logic               full,
   output logic               empty
);
   import qif_pkg::*;

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wrap_inc(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= wrap_inc(rd_ptr_ff);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   `QIF_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `QIF_ASSERT_NEXT(a_full_holds, clock, reset, full && !pop, count_ff == CNT_W'(DEPTH))
endmodule

// ===== sv/qif_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a side payload.
module qif_div #(
   parameter int unsigned NUM_W  = 8,
   parameter int unsigned DEN_W  = 8,
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              adv,
   input  logic              in_valid,
   input  logic [NUM_W-1:0]  in_num,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [NUM_W-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);
   logic [NUM_W-1:0]  nq_ff   [NUM_W];
   logic [DEN_W-1:0]  rem_ff  [NUM_W];
   logic [DEN_W-1:0]  den_ff  [NUM_W];
   logic [SIDE_W-1:0] side_ff [NUM_W];
   logic              vld_ff  [NUM_W];

   for (genvar k = 0; k < NUM_W; k++) begin : g_stage
      logic [NUM_W-1:0]  nq_prev;
      logic [DEN_W-1:0]  rem_prev, den_prev;
      logic [SIDE_W-1:0] side_prev;
      logic              vld_prev;
      logic [DEN_W:0]    trial;
      logic              fits;
      logic [DEN_W-1:0]  rem_in;
      logic [NUM_W-1:0]  nq_in;

      if (k == 0) begin : g_first
         assign nq_prev   = in_num;
         assign rem_prev  = '0;
         assign den_prev  = in_den;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign nq_prev   = nq_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      assign trial  = {rem_prev, nq_prev[NUM_W-1]};
      assign fits   = trial >= {1'b0, den_prev};
      assign rem_in = fits ? DEN_W'(trial - {1'b0, den_prev}) : trial[DEN_W-1:0];
      assign nq_in  = {nq_prev[NUM_W-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[k]   <= nq_in;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= den_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];
endmodule

// ===== sv/qif_back.sv =====
// Back end: coupling division, Euler step, spike timing and the output register.
`include "qif_neuron_update_defines.svh"
module qif_back (
   input  logic               clock,
   input  logic               reset,
   input  qif_pkg::cfg_type   cfg,
   input  logic               empty,
   input  qif_pkg::entry_type pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_new_potential,
   output logic               rsp_spiked,
   output logic signed [31:0] rsp_new_last_spike,
   output logic [20:0]        rsp_new_refractory,
   output logic               rsp_integrated,
   output logic               rsp_counts_for_average
);
   import qif_pkg::*;

   localparam int unsigned ITEM_W = $bits(item_type);
   localparam int unsigned SIDE2_W = ITEM_W + 34;
   localparam logic signed [51:0] V_MAX = 52'sd2147483647;
   localparam logic signed [51:0] V_MIN = -52'sd2147483648;

   logic adv;
   assign adv = !rsp_valid || rsp_ready;
   assign pop = adv && !empty;

   // Coupling division.
   logic                  d1_valid;
   logic [COUP_NUM_W-1:0] d1_quot;
   logic [ITEM_W-1:0]     d1_side;
   item_type              d1_item;

   qif_div #(.NUM_W(COUP_NUM_W), .DEN_W(DEG_W), .SIDE_W(ITEM_W)) u_coup_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(!empty), .in_num(pop_data.coup_num), .in_den(pop_data.degree),
      .in_side(pop_data.item),
      .out_valid(d1_valid), .out_quot(d1_quot), .out_side(d1_side)
   );
   assign d1_item = item_type'(d1_side);

   // Stage 1: square and current.
   logic               s1_valid_ff;
   item_type           s1_item_ff;
   logic [63:0]        s1_sq_ff;
   logic signed [49:0] s1_cur_ff;
   logic [31:0]        vm;
   logic signed [49:0] coup_term, stim_term, s1_cur_in;

   assign vm = d1_item.potential[31] ? (~d1_item.potential + 32'd1) : d1_item.potential;
   assign coup_term = d1_item.coupled ? $signed({3'b0, d1_quot}) : '0;
   assign stim_term = d1_item.stim_on ? 50'(cfg.stimulus_level) : '0;
   assign s1_cur_in = 50'(d1_item.drive) + coup_term + stim_term;

   // Stage 2: derivative.  Stage 3: magnitude.
   logic               s2_valid_ff, s3_valid_ff;
   item_type           s2_item_ff, s3_item_ff;
   logic signed [49:0] s2_dv_ff;
   logic [48:0]        s3_mag_ff;
   logic               s3_neg_ff;

   // Stage 4: partial products.  Stage 5: scaled increment.
   logic               s4_valid_ff, s5_valid_ff;
   item_type           s4_item_ff, s5_item_ff;
   logic               s4_neg_ff, s5_neg_ff;
   logic [48:0]        s4_phi_ff;
   logic [63:0]        s4_plo_ff;
   logic [49:0]        s5_inc_ff;

   // Stage 6: saturated potential.  Stage 7: threshold test.
   logic               s6_valid_ff, s7_valid_ff;
   item_type           s6_item_ff, s7_item_ff;
   logic signed [31:0] s6_v_ff, s7_v_ff;
   logic               s7_spike_ff, s7_vzero_ff;
   logic signed [51:0] vsum;
   logic signed [31:0] s6_v_in;
   logic               spike_in;

   assign vsum = s5_neg_ff ? (52'(s5_item_ff.potential) - $signed({2'b0, s5_inc_ff}))
                           : (52'(s5_item_ff.potential) + $signed({2'b0, s5_inc_ff}));
   assign s6_v_in = (vsum > V_MAX) ? 32'sh7FFFFFFF :
                    (vsum < V_MIN) ? 32'sh80000000 : vsum[31:0];
   assign spike_in = s6_item_ff.live
                  && ($signed({s6_v_ff[31], s6_v_ff}) >= $signed({2'b00, cfg.threshold}));

   // Spike timing division.
   logic                 d2_valid;
   logic [SPK_NUM_W-1:0] d2_quot;
   logic [SIDE2_W-1:0]   d2_side;
   item_type             d2_item;
   logic signed [31:0]   d2_v;
   logic                 d2_spike, d2_vzero;

   qif_div #(.NUM_W(SPK_NUM_W), .DEN_W(SPK_DEN_W), .SIDE_W(SIDE2_W)) u_spk_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s7_valid_ff), .in_num({cfg.ticks_per_second, 17'b0}),
      .in_den(s7_v_ff[30:0]),
      .in_side({s7_item_ff, s7_v_ff, s7_spike_ff, s7_vzero_ff}),
      .out_valid(d2_valid), .out_quot(d2_quot), .out_side(d2_side)
   );
   assign {d2_item, d2_v, d2_spike, d2_vzero} = d2_side;

   // Stage 8: clamped quotients.  Stage 9: final fields.
   logic               s8_valid_ff, s9_valid_ff;
   item_type           s8_item_ff, s9_item_ff;
   logic signed [31:0] s8_v_ff, s9_v_ff;
   logic               s8_spike_ff, s9_spike_ff;
   logic [20:0]        s8_q2_ff, s9_refr_ff;
   logic [30:0]        s8_q1_ff;
   logic signed [31:0] s9_last_ff;
   logic [35:0]        q_half;
   logic [20:0]        q2_in;
   logic [30:0]        q1_in;
   logic signed [32:0] last_sum;

   assign q_half = d2_quot[SPK_NUM_W-1:1];
   assign q2_in = d2_vzero ? REFR_MAX :
                  (d2_quot > SPK_NUM_W'(REFR_MAX)) ? REFR_MAX : d2_quot[20:0];
   assign q1_in = d2_vzero ? 31'h7FFFFFFF :
                  (q_half > 36'h07FFFFFFF) ? 31'h7FFFFFFF : q_half[30:0];
   assign last_sum = {s8_item_ff.now_tick[31], s8_item_ff.now_tick} + $signed({2'b0, s8_q1_ff});

   logic signed [33:0] since_last;
   assign since_last = {{2{s9_item_ff.now_tick[31]}}, s9_item_ff.now_tick}
                     - {{2{s9_last_ff[31]}}, s9_last_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         s8_valid_ff <= 1'b0;
         s9_valid_ff <= 1'b0;
         rsp_valid   <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= d1_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_valid_ff <= s5_valid_ff;
         s7_valid_ff <= s6_valid_ff;
         s8_valid_ff <= d2_valid;
         s9_valid_ff <= s8_valid_ff;
         rsp_valid   <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= d1_item;
         s1_sq_ff   <= vm * vm;
         s1_cur_ff  <= s1_cur_in;

         s2_item_ff <= s1_item_ff;
         s2_dv_ff   <= $signed({2'b0, s1_sq_ff[63:16]}) + s1_cur_ff;

         s3_item_ff <= s2_item_ff;
         s3_neg_ff  <= s2_dv_ff[49];
         s3_mag_ff  <= s2_dv_ff[49] ? 49'(-s2_dv_ff) : s2_dv_ff[48:0];

         s4_item_ff <= s3_item_ff;
         s4_neg_ff  <= s3_neg_ff;
         s4_phi_ff  <= 49'(s3_mag_ff[48:32]) * 49'(cfg.step_size);
         s4_plo_ff  <= 64'(s3_mag_ff[31:0]) * 64'(cfg.step_size);

         s5_item_ff <= s4_item_ff;
         s5_neg_ff  <= s4_neg_ff;
         s5_inc_ff  <= 50'(s4_phi_ff) + 50'(s4_plo_ff[63:32]);

         s6_item_ff <= s5_item_ff;
         s6_v_ff    <= s6_v_in;

         s7_item_ff  <= s6_item_ff;
         s7_v_ff     <= s6_v_ff;
         s7_spike_ff <= spike_in;
         s7_vzero_ff <= s6_v_ff == '0;

         s8_item_ff  <= d2_item;
         s8_v_ff     <= d2_v;
         s8_spike_ff <= d2_spike;
         s8_q2_ff    <= q2_in;
         s8_q1_ff    <= q1_in;

         s9_item_ff  <= s8_item_ff;
         s9_spike_ff <= s8_spike_ff;
         if (!s8_item_ff.live) begin
            s9_v_ff    <= s8_item_ff.potential;
            s9_last_ff <= s8_item_ff.last_spike_tick;
            s9_refr_ff <= s8_item_ff.refractory_ticks;
         end else if (s8_spike_ff) begin
            s9_v_ff    <= -s8_v_ff;
            s9_last_ff <= (last_sum[32:31] == 2'b01) ? 32'sh7FFFFFFF : last_sum[31:0];
            s9_refr_ff <= s8_q2_ff;
         end else begin
            s9_v_ff    <= s8_v_ff;
            s9_last_ff <= s8_item_ff.last_spike_tick;
            s9_refr_ff <= s8_item_ff.refractory_ticks;
         end

         rsp_new_potential      <= s9_v_ff;
         rsp_spiked             <= s9_spike_ff;
         rsp_new_last_spike     <= s9_last_ff;
         rsp_new_refractory     <= s9_refr_ff;
         rsp_integrated         <= s9_item_ff.live;
         rsp_counts_for_average <= since_last > $signed({13'b0, s9_refr_ff});
      end
   end

   `QIF_ASSERT_IMPL(a_spike_integrated, clock, reset, rsp_valid && rsp_spiked, rsp_integrated)
   `QIF_ASSERT_IMPL(a_spike_refr, clock, reset, rsp_valid && rsp_spiked, rsp_new_refractory <= REFR_MAX)
endmodule

// ===== tb/qif_neuron_update_checker.sv =====
// Checker that predicts and compares every neuron update result of qif_neuron_update.
`timescale 1ns / 1ps

module qif_neuron_update_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic signed [31:0]              req_now_tick,
   input  logic signed [31:0]              req_potential,
   input  logic signed [31:0]              req_drive,
   input  logic [15:0]                     req_active_neighbours,
   input  logic [15:0]                     req_degree,
   input  logic signed [31:0]              req_last_spike_tick,
   input  logic [20:0]                     req_refractory_ticks,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic signed [31:0]              rsp_new_potential,
   input  logic                            rsp_spiked,
   input  logic signed [31:0]              rsp_new_last_spike,
   input  logic [20:0]                     rsp_new_refractory,
   input  logic                            rsp_integrated,
   input  logic                            rsp_counts_for_average,
   input  logic                            csr_write,
   input  logic [qif_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [qif_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                              failures,
   output int                              pending
);
   import qif_pkg::*;

   typedef struct packed {
      logic signed [31:0] potential;
      logic               spiked;
      logic signed [31:0] last_spike;
      logic [20:0]        refractory;
      logic               integrated;
      logic               counts;
   } neuron_state_type;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   cfg_type          shadow_cfg;
   neuron_state_type expected_states[$];

   function automatic longint clamp32(longint x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
   endfunction

   function automatic neuron_state_type integrate_neuron(cfg_type c);
      neuron_state_type res;
      longint now, v, last, refr, cur, dv, inc;
      logic [63:0] vm, mag, r, num, q2, q1;
      now = req_now_tick;
      v = req_potential;
      last = req_last_spike_tick;
      refr = longint'({1'b0, req_refractory_ticks});
      res.spiked = 1'b0;
      res.integrated = 1'b0;
      if (now - last > refr) begin
         res.integrated = 1'b1;
         cur = req_drive;
         if (req_degree != 0)
            cur += longint'((64'(c.coupling_gain) * 64'(req_active_neighbours))
                            / 64'(req_degree));
         if (now >= c.stimulus_start && now <= c.stimulus_end)
            cur += longint'(c.stimulus_level);
         vm = (v < 0) ? 64'(-v) : 64'(v);
         dv = longint'((vm * vm) >> 16) + cur;
         mag = (dv < 0) ? 64'(-dv) : 64'(dv);
         r = (mag >> 32) * 64'(c.step_size)
             + (((mag & 64'hFFFF_FFFF) * 64'(c.step_size)) >> 32);
         inc = (dv < 0) ? -longint'(r) : longint'(r);
         v = clamp32(v + inc);
         if (v >= longint'({1'b0, c.threshold})) begin
            res.spiked = 1'b1;
            num = 64'(c.ticks_per_second) << 16;
            if (v > 0) begin
               q2 = (2 * num) / 64'(v);
               q1 = num / 64'(v);
            end else begin
               q2 = 64'(REFR_MAX);
               q1 = 64'(S32_MAX);
            end
            if (q2 > 64'(REFR_MAX)) q2 = 64'(REFR_MAX);
            if (q1 > 64'(S32_MAX)) q1 = 64'(S32_MAX);
            refr = longint'(q2);
            last = clamp32(now + longint'(q1));
            v = -v;
         end
      end
      res.counts = (now - last > refr);
      res.potential = v[31:0];
      res.last_spike = last[31:0];
      res.refractory = refr[20:0];
      return res;
   endfunction

   assign pending = expected_states.size();

   always @(posedge clock) begin
      neuron_state_type want, got;
      if (reset) begin
         shadow_cfg.threshold <= 31'd6553600;
         shadow_cfg.coupling_gain <= 31'd983040000;
         shadow_cfg.step_size <= 32'd429497;
         shadow_cfg.ticks_per_second <= 20'd10000;
         shadow_cfg.stimulus_level <= 32'sd196608;
         shadow_cfg.stimulus_start <= 32'sd0;
         shadow_cfg.stimulus_end <= 32'sd300000;
         expected_states.delete();
         failures <= 0;
      end else begin
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_THRESHOLD: shadow_cfg.threshold <= csr_data[30:0];
               CSR_COUPLING_GAIN: shadow_cfg.coupling_gain <= csr_data[30:0];
               CSR_STEP_SIZE: shadow_cfg.step_size <= csr_data;
               CSR_TICKS_PER_SEC: shadow_cfg.ticks_per_second <= csr_data[19:0];
               CSR_STIM_LEVEL: shadow_cfg.stimulus_level <= csr_data;
               CSR_STIM_START: shadow_cfg.stimulus_start <= csr_data;
               CSR_STIM_END: shadow_cfg.stimulus_end <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_states.insert(expected_states.size(), integrate_neuron(shadow_cfg));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_new_potential, rsp_spiked, rsp_new_last_spike,
                    rsp_new_refractory, rsp_integrated, rsp_counts_for_average};
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected item: V=%0d spk=%0d last=%0d refr=%0d",
                        $time, got.potential, got.spiked, got.last_spike,
                        got.refractory);
               failures <= failures + 1;
            end else begin
               want = expected_states.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch, expected V=%0d spk=%0d last=%0d refr=%0d int=%0d cnt=%0d",
                           $time, want.potential, want.spiked, want.last_spike,
                           want.refractory, want.integrated, want.counts);
                  $display("%0t:           actual V=%0d spk=%0d last=%0d refr=%0d int=%0d cnt=%0d",
                           $time, got.potential, got.spiked, got.last_spike,
                           got.refractory, got.integrated, got.counts);
                  failures <= failures + 1;
               end
            end
         end
      end
   end

endmodule

// ===== tb/tb_qif_neuron_update.sv =====
// Top of the testbench: drives stimulus into qif_neuron_update and gives the verdict.
`timescale 1ns / 1ps

module tb_qif_neuron_update;
   import qif_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [31:0] req_now_tick, req_potential, req_drive, req_last_spike_tick;
   logic [15:0] req_active_neighbours, req_degree;
   logic [20:0] req_refractory_ticks;
   logic signed [31:0] rsp_new_potential, rsp_new_last_spike;
   logic rsp_spiked, rsp_integrated, rsp_counts_for_average;
   logic [20:0] rsp_new_refractory;
   logic csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int failures, pending, cycles;
   bit calm, hold_request, hold_done;
   cfg_type active_cfg;

   qif_neuron_update dut (.*);

   qif_neuron_update_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off on request.
   initial begin
      hold_done = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
      end
   end

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
   endtask

   task automatic write_config(cfg_type c);
      write_reg(CSR_THRESHOLD, 32'(c.threshold));
      write_reg(CSR_COUPLING_GAIN, 32'(c.coupling_gain));
      write_reg(CSR_STEP_SIZE, c.step_size);
      write_reg(CSR_TICKS_PER_SEC, 32'(c.ticks_per_second));
      write_reg(CSR_STIM_LEVEL, c.stimulus_level);
      write_reg(CSR_STIM_START, c.stimulus_start);
      write_reg(CSR_STIM_END, c.stimulus_end);
      csr_write <= 1'b0;
      active_cfg = c;
   endtask

   task automatic send_neuron(logic signed [31:0] now, logic signed [31:0] v,
                              logic signed [31:0] drv, logic [15:0] cnt,
                              logic [15:0] deg, logic signed [31:0] last,
                              logic [20:0] refr);
      while (!calm && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_now_tick <= now;
      req_potential <= v;
      req_drive <= drv;
      req_active_neighbours <= cnt;
      req_degree <= deg;
      req_last_spike_tick <= last;
      req_refractory_ticks <= refr;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic run_directed;
      int thr;
      thr = int'(active_cfg.threshold);
      send_neuron(100, 32'sh7FFF_FFFF, 0, 5, 3, -1000, 10);
      send_neuron(100, 32'sh8000_0000, 0, 0, 0, -1000, 10);
      send_neuron(100, 0, 32'sh7FFF_FFFF, 16'hFFFF, 1, -1000, 0);
      send_neuron(100, 0, 32'sh8000_0000, 16'hFFFF, 0, -1000, 0);
      send_neuron(100, 65536, 0, 16'hFFFF, 16'hFFFF, 50, 21'h1F_FFFF);
      send_neuron(100, 65536, 0, 7, 2, 90, 10);
      send_neuron(100, 65536, 0, 7, 2, 89, 10);
      send_neuron(32'sh7FFF_FFF0, thr + 65536, 0, 0, 0, 0, 0);
      send_neuron(32'sh8000_0000, thr, 0, 0, 0, 32'sh7FFF_FFFF, 0);
      send_neuron(32'sh7FFF_FFFF, thr - 1, 1000, 1, 1, 32'sh8000_0000, 21'h1F_FFFF);
      send_neuron(active_cfg.stimulus_start, thr - 65536, 0, 0, 0, -50000, 5);
      send_neuron(active_cfg.stimulus_end, thr - 65536, 0, 0, 0, -50000, 5);
      send_neuron(active_cfg.stimulus_end + 1, thr - 65536, 0, 0, 0, -50000, 5);
      send_neuron(0, -thr, -65536, 3, 4, -3000000, 2000000);
   endtask

   task automatic run_random(int n);
      logic signed [31:0] now, v, last;
      logic [20:0] refr;
      logic [15:0] deg;
      int thr, pick;
      thr = int'(active_cfg.threshold);
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(9);
         now = (pick < 7) ? $signed($urandom_range(401000)) - 1000 : $urandom;
         pick = $urandom_range(9);
         if (pick < 4) v = thr - $urandom_range(262144) + $urandom_range(524288);
         else if (pick < 7) v = $signed($urandom_range(2621440)) - 1310720;
         else v = $urandom;
         pick = $urandom_range(3);
         refr = 21'((pick < 2) ? $urandom_range(2000) :
                    (pick == 2) ? $urandom_range(2000000) : $urandom);
         last = ($urandom_range(9) < 6) ? now - $signed($urandom_range(2 * refr + 2))
                                        : $urandom;
         deg = ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom);
         send_neuron(now, v, $urandom_range(9) < 6 ? $signed($urandom_range(20000)) - 10000
                     : $urandom, 16'($urandom), deg, last, refr);
      end
   endtask

   initial begin
      cfg_type c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_now_tick = '0;
      req_potential = '0;
      req_drive = '0;
      req_active_neighbours = '0;
      req_degree = '0;
      req_last_spike_tick = '0;
      req_refractory_ticks = '0;
      csr_write = 1'b0;
      csr_index = '0;
      csr_data = '0;
      calm = 1'b0;
      hold_request = 1'b0;
      active_cfg = '{31'd6553600, 31'd983040000, 32'd429497, 20'd10000,
                     32'sd196608, 32'sd0, 32'sd300000};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      run_directed();
      run_random(100);
      drain();

      c = '{31'd65536, 31'd0, 32'hFFFF_FFFF, 20'd1000000,
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
      write_config(c);
      run_directed();
      hold_request = 1'b1;
      run_random(100);
      drain();

      c = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd1, 20'd1,
            32'sh8000_0000, 32'sd1000, 32'sd2000};
      write_config(c);
      run_random(60);
      drain();

      calm = 1'b1;
      c = '{31'd655360, 31'd6553600, 32'd42949673, 20'd1000,
            -32'sd655360, 32'sd100000, 32'sd200000};
      write_config(c);
      run_random(120);
      drain();
      calm = 1'b0;

      c = '{31'd1310720, 31'd65536000, 32'd4294967, 20'd500000,
            32'sd6553600, 32'sh8000_0000, 32'sd50000};
      write_config(c);
      run_random(120);
      drain();

      if (failures == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/qif_pkg.sv
sv/qif_front.sv
sv/qif_queue.sv
sv/qif_div.sv
sv/qif_back.sv
sv/qif_neuron_update.sv
tb/qif_neuron_update_checker.sv
tb/tb_qif_neuron_update.sv
